### rtl/core/olpd_pkg.sv
// Package for the ordered list block: request codes, status codes and sequencer states.
// Has no dependencies; every other file of the block imports it.
package olpd_pkg;

  localparam int unsigned ReqTypeW  = 3;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned PositionW = 5;
  localparam int unsigned CountW    = 5;
  localparam int unsigned ValueW    = 32;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_APPEND      = 3'd0,
    REQ_REMOVE_HEAD = 3'd1,
    REQ_REMOVE_TAIL = 3'd2,
    REQ_REMOVE_POS  = 3'd3,
    REQ_REMOVE_MID  = 3'd4
  } olpd_req_e;

  typedef enum logic [StatusW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } olpd_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAPT,
    S_SHIFT,
    S_DONE
  } olpd_state_e;

endpackage

### rtl/core/olpd_if.sv
// Valid/ready channel interfaces for the request and the result beats.
// Depends on olpd_pkg for the field widths.
interface olpd_req_if;
  import olpd_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [ReqTypeW-1:0]         req_type;
  logic signed [ValueW-1:0]    item_value;
  logic [PositionW-1:0]        position;

  modport source (output valid, req_type, item_value, position, input ready);
  modport sink   (input valid, req_type, item_value, position, output ready);
endinterface

interface olpd_rsp_if;
  import olpd_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [StatusW-1:0]          status;
  logic [CountW-1:0]           count_after;
  logic signed [ValueW-1:0]    removed_value;

  modport source (output valid, status, count_after, removed_value, input ready);
  modport sink   (input valid, status, count_after, removed_value, output ready);
endinterface

### rtl/core/olpd_store.sv
// Entry store: one write port and one read port with registered read data.
// Depends on olpd_pkg for the value width.
module olpd_store import olpd_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [ValueW-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [DEPTH];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ordered_list_with_positional_delete_core.sv
// Ordered list with positional delete: top level with the sequencer and the result register.
// Depends on olpd_pkg, the olpd_req_if / olpd_rsp_if interfaces and olpd_store.
//
// Usage. Requests arrive as beats on req_i and each one yields exactly one result
// beat on rsp_o. Both channels move a beat on a rising edge where valid and ready
// are high. The list keeps up to DEPTH signed values in insertion order, index 0
// being the head, in a single-port-read, single-port-write store.
//
// Timing. An append, and every request that turns out to be a no-op, is settled
// in the cycle it is accepted; its result then passes from the S_DONE state into
// the output register, from which it is offered on rsp_o. A removal at index k of
// a list holding n entries reads the victim, then walks the entries behind it one
// place towards the head, one entry per cycle through the shared read and write
// ports of the store, and its result then passes through S_DONE in the same way.
// req_i.ready is high only while the sequencer is idle, so a new request is taken
// only after the previous result has left the sequencer; for a removal the
// compaction walk sets how soon that is.
//
// Reset clears the entry count and the sequencer; the stored values are not
// cleared, since no entry at or beyond the count is ever used. When the receiver
// stalls, the finished result waits in the output register and the block still
// takes the next request; a second result waits in the sequencer until the
// output register frees up.
module ordered_list_with_positional_delete_core import olpd_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  olpd_req_if.sink      req_i,
  olpd_rsp_if.source    rsp_o
);

  // Index width, count width, and a width wide enough for both the count and a position.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > PositionW) ? CW : PositionW;

  olpd_state_e            state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [StatusW-1:0]     res_status_q, res_status_d;
  logic [ValueW-1:0]      res_removed_q, res_removed_d;

  logic                   out_valid_q, out_valid_d;
  logic [StatusW-1:0]     out_status_q;
  logic [CountW-1:0]      out_count_q;
  logic [ValueW-1:0]      out_removed_q;
  logic                   out_load;

  logic                   st_we;
  logic [AW-1:0]          st_waddr;
  logic [ValueW-1:0]      st_wdata;
  logic [AW-1:0]          st_raddr;
  logic [ValueW-1:0]      st_rdata;

  logic [XW-1:0]          cnt_x;
  logic [XW-1:0]          pos_x;
  logic [XW-1:0]          pos_m1;
  logic [CW-1:0]          cnt_m1;
  logic [CW-1:0]          cnt_half;
  logic [AW-1:0]          ptr_p1;
  logic [CW-1:0]          ptr_c;

  olpd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Helper values for the index arithmetic.
  assign cnt_x    = XW'(count_q);
  assign pos_x    = XW'(req_i.position);
  assign pos_m1   = pos_x - XW'(1);
  assign cnt_m1   = count_q - CW'(1);
  assign cnt_half = count_q >> 1;
  assign ptr_p1   = ptr_q + AW'(1);
  assign ptr_c    = CW'(ptr_q);

  // The sequencer. The victim is read first; after that each cycle writes the
  // entry behind the gap one place forward while the next one is being read.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    res_status_d  = res_status_q;
    res_removed_d = res_removed_q;
    st_we         = 1'b0;
    st_waddr      = ptr_q;
    st_wdata      = st_rdata;
    st_raddr      = ptr_q;
    req_i.ready   = 1'b0;
    out_load      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          res_status_d  = STAT_DONE;
          res_removed_d = '0;
          state_d       = S_DONE;
          unique case (req_i.req_type)
            REQ_APPEND: begin
              if (count_q >= CW'(DEPTH)) begin
                res_status_d = STAT_FULL;
              end else begin
                st_we    = 1'b1;
                st_waddr = count_q[AW-1:0];
                st_wdata = req_i.item_value;
                count_d  = count_q + CW'(1);
              end
            end
            REQ_REMOVE_HEAD, REQ_REMOVE_TAIL, REQ_REMOVE_POS, REQ_REMOVE_MID: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
              end else if (req_i.req_type == REQ_REMOVE_POS &&
                           (pos_x == '0 || pos_x > cnt_x)) begin
                res_status_d = STAT_RANGE;
              end else begin
                state_d = S_CAPT;
                unique case (req_i.req_type)
                  REQ_REMOVE_HEAD: ptr_d = '0;
                  REQ_REMOVE_TAIL: ptr_d = cnt_m1[AW-1:0];
                  REQ_REMOVE_POS:  ptr_d = pos_m1[AW-1:0];
                  default:         ptr_d = cnt_half[AW-1:0];
                endcase
                st_raddr = ptr_d;
              end
            end
            default: begin
              // Unknown request codes leave the list alone and report done.
            end
          endcase
        end
      end

      S_CAPT: begin
        res_removed_d = st_rdata;
        if (ptr_c + CW'(1) < count_q) begin
          st_raddr = ptr_p1;
          state_d  = S_SHIFT;
        end else begin
          count_d = cnt_m1;
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        st_we    = 1'b1;
        st_waddr = ptr_q;
        st_wdata = st_rdata;
        ptr_d    = ptr_p1;
        if (ptr_c + CW'(2) < count_q) begin
          st_raddr = ptr_q + AW'(2);
        end else begin
          count_d = cnt_m1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q         <= ptr_d;
    res_status_q  <= res_status_d;
    res_removed_q <= res_removed_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_count_q   <= cnt_x[CountW-1:0];
      out_removed_q <= res_removed_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.count_after   = out_count_q;
  assign rsp_o.removed_value = out_removed_q;

endmodule

### rtl/core/olpd_checker.sv
// Port-level checks for the ordered list block, bound to its top level.
// Depends on olpd_pkg for status codes and widths.
module olpd_checker import olpd_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [StatusW-1:0]   rsp_status,
  input logic [CountW-1:0]    rsp_count_after,
  input logic [ValueW-1:0]    rsp_removed_value
);

  // A result that has not been taken stays offered with the same status and removed value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_removed_value) &&
                                $stable(rsp_status))
    else $error("result beat changed while stalled");

  // The sequencer is busy in the cycle after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while sequencer still busy");

  // A no-op result (any status other than done) reports a removed value of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != STAT_DONE |-> rsp_removed_value == '0)
    else $error("no-op result carries a removed value");

  // A refused append means the list is full; a removal from an empty list leaves it empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status == STAT_FULL || rsp_status == STAT_EMPTY) |->
      (rsp_status == STAT_FULL ? rsp_count_after == CountW'(DEPTH)
                               : rsp_count_after == '0))
    else $error("count does not match the no-op status");

endmodule

bind ordered_list_with_positional_delete_core olpd_checker #(
  .DEPTH (DEPTH)
) u_olpd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid         (req_i.valid),
  .req_ready         (req_i.ready),
  .rsp_valid         (rsp_o.valid),
  .rsp_ready         (rsp_o.ready),
  .rsp_status        (rsp_o.status),
  .rsp_count_after   (rsp_o.count_after),
  .rsp_removed_value (rsp_o.removed_value)
);
